[hdl/gb5_pkg.sv]
// ----------------------------------------------------------------------------
// gb5_pkg
// Shared types and constants of the 5x5 Gaussian blur: kernel weights,
// divide-by-273 reciprocal, register indexes and the result beat type.
// ----------------------------------------------------------------------------
package gb5_pkg;

	localparam int unsigned PIX_W      = 8;
	localparam int unsigned CFG_W      = 12;
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned H_W        = 12;
	localparam int unsigned ROW_W      = 11;
	localparam int unsigned MAX_HEIGHT = 2048;
	localparam int unsigned OUTQ_DEPTH = 8;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

	localparam int unsigned WGT_W  = 6;
	localparam int unsigned RSUM_W = 15;
	localparam int unsigned SUM_W  = 17;

	localparam logic [WGT_W-1:0] KW [5][5] = '{
		'{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
		'{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
		'{6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
		'{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
		'{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
	};

	// floor(x / 273) = (x * DIV_RECIP) >> DIV_SHIFT for every x below 2^17
	localparam int unsigned RECIP_W   = 18;
	localparam int unsigned DIV_SHIFT = 26;
	localparam logic [RECIP_W-1:0] DIV_RECIP = 18'd245821;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             last;
	} res_t;

endpackage

[hdl/gb5_ram.sv]
// ----------------------------------------------------------------------------
// gb5_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module gb5_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/gb5_outq.sv]
// ----------------------------------------------------------------------------
// gb5_outq
// Result queue between the blur pipeline and the output channel. The
// pipeline pushes without backpressure; the top level keeps it from filling.
// ----------------------------------------------------------------------------
module gb5_outq #(
	parameter int unsigned DEPTH = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gb5_pkg::res_t push_data,
	output logic          valid,
	input  logic          ready,
	output gb5_pkg::res_t data
);
	import gb5_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	res_t           ent_q [DEPTH];
	logic [PW-1:0]  head_q;
	logic [PW-1:0]  tail_q;
	logic [CW-1:0]  count_q;
	logic           pop;

	assign valid = (count_q != '0);
	assign pop   = valid && ready;
	assign data  = ent_q[head_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[tail_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + PW'(1);
			end
			if (pop) begin
				head_q <= (head_q == PW'(DEPTH - 1)) ? '0 : head_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/gaussian_blur_5x5_top.sv]
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_top
// Streaming 5x5 Gaussian blur (mask sum 273) over an 8-bit raster image
// with a black border, one pixel beat per clock.
// ----------------------------------------------------------------------------
// The block takes one input beat every clock cycle and gives the blurred
// pixel of image position k on the beat 2W+2 input beats later, once it
// has passed through the pipeline (line buffer read, window, row
// sums, column sum, divide). Four line buffers live in one MAX_WIDTH x 32
// RAM read and written once per cycle at the current column, which with
// the 25-byte window register sets the one-pixel-per-clock rate. After the
// last image pixel, drain beats (func = 1) flush the remaining outputs;
// drain beats sent earlier are dropped. in_ready falls while eight results
// are outstanding on the output side and for one cycle after each
// configuration write; a width or height write restarts the frame. The line
// buffers need no clearing after reset.
// ----------------------------------------------------------------------------
module gaussian_blur_5x5_top #(
	parameter int unsigned MAX_WIDTH = 2048
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gb5_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gb5_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            func,
	input  logic [gb5_pkg::PIX_W-1:0]       pixel_in,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [gb5_pkg::PIX_W-1:0]       pixel_out,
	output logic                            last_of_frame
);
	import gb5_pkg::*;

	localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
	localparam int unsigned WEW    = $clog2(MAX_WIDTH + 1);
	localparam int unsigned CLW    = (WEW > CFG_W) ? WEW : CFG_W;
	localparam int unsigned WX     = WEW + 1;
	localparam int unsigned AREA_W = WEW + H_W;
	localparam int unsigned ITEM_W = $clog2(MAX_WIDTH * (MAX_HEIGHT + 2) + 3);
	localparam int unsigned PEND_W = $clog2(OUTQ_DEPTH + 1);
	localparam int unsigned LB_W   = 4 * PIX_W;
	localparam int unsigned PROD_W = SUM_W + RECIP_W;

	// configuration
	logic [CFG_W-1:0]  width_q;
	logic [CFG_W-1:0]  height_q;
	logic              hold_q;
	logic [WEW-1:0]    w_eff;
	logic [H_W-1:0]    h_eff;
	logic [AREA_W-1:0] area;
	logic [ITEM_W-1:0] total_q;
	logic [ITEM_W-1:0] thresh_q;
	logic              cfg_wr;
	logic              cfg_hit;

	// frame counters
	logic [ITEM_W-1:0] items_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [COL_W-1:0]  out_col_q;
	logic [PEND_W-1:0] pend_q;

	// input side
	logic              acc;
	logic              take;
	logic              taken_lt;
	logic              emit;
	logic              last;
	logic              col_wrap;
	logic              ocol_wrap;
	logic [4:0]        rmask;
	logic [4:0]        cmask;
	logic [PIX_W-1:0]  val;

	// stage 1: line buffer read, window shift
	logic              v_s1;
	logic              e_s1;
	logic              last_s1;
	logic [PIX_W-1:0]  val_s1;
	logic [COL_W-1:0]  col_s1;
	logic [4:0]        rmask_s1;
	logic [4:0]        cmask_s1;
	logic              fwd_s1;
	logic [LB_W-1:0]   fwd_data_s1;
	logic [LB_W-1:0]   ram_rdata;
	logic [LB_W-1:0]   lb_rd;
	logic [LB_W-1:0]   lb_wdata;
	logic [PIX_W-1:0]  vec [5];
	logic [PIX_W-1:0]  win_q [5][5];

	// stage 2: row sums
	logic              e_s2;
	logic              last_s2;
	logic [4:0]        rmask_s2;
	logic [4:0]        cmask_s2;
	logic [RSUM_W-1:0] rsum [5];

	// stage 3: column sum
	logic              e_s3;
	logic              last_s3;
	logic [RSUM_W-1:0] rsum_s3 [5];

	// stage 4: divide by 273
	logic              e_s4;
	logic              last_s4;
	logic [SUM_W-1:0]  sum_s4;
	logic [PROD_W-1:0] prod;
	res_t              push_data;
	res_t              q_data;
	logic              pop;

	// effective frame size
	always_comb begin
		if (width_q == '0) begin
			w_eff = WEW'(1);
		end else if (CLW'(width_q) > CLW'(MAX_WIDTH)) begin
			w_eff = WEW'(MAX_WIDTH);
		end else begin
			w_eff = WEW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = H_W'(1);
		end else if (height_q > H_W'(MAX_HEIGHT)) begin
			h_eff = H_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	assign area      = AREA_W'(w_eff) * AREA_W'(h_eff);
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign cfg_hit   = cfg_wr && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

	// accept decode
	assign in_ready  = (pend_q < PEND_W'(OUTQ_DEPTH)) && !hold_q;
	assign acc       = in_valid && in_ready;
	assign taken_lt  = (items_q < total_q);
	assign take      = acc && !(func && taken_lt);
	assign emit      = (items_q >= thresh_q);
	assign val       = (!func && taken_lt) ? pixel_in : '0;
	assign col_wrap  = ((WEW'(col_q) + WEW'(1)) == w_eff);
	assign ocol_wrap = ((WEW'(out_col_q) + WEW'(1)) == w_eff);
	assign last      = ({1'b0, out_row_q} == (h_eff - H_W'(1))) && ocol_wrap;

	always_comb begin
		rmask[0] = (out_row_q >= ROW_W'(2));
		rmask[1] = (out_row_q != '0);
		rmask[2] = 1'b1;
		rmask[3] = ((H_W'(out_row_q) + H_W'(1)) < h_eff);
		rmask[4] = ((H_W'(out_row_q) + H_W'(2)) < h_eff);
		cmask[0] = (out_col_q >= COL_W'(2));
		cmask[1] = (out_col_q != '0);
		cmask[2] = 1'b1;
		cmask[3] = ((WX'(out_col_q) + WX'(1)) < WX'(w_eff));
		cmask[4] = ((WX'(out_col_q) + WX'(2)) < WX'(w_eff));
	end

	assign pop = out_valid && out_ready;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= CFG_W'(512);
			height_q  <= CFG_W'(512);
			hold_q    <= 1'b1;
			total_q   <= '0;
			thresh_q  <= '0;
			items_q   <= '0;
			col_q     <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			pend_q    <= '0;
			v_s1      <= 1'b0;
			e_s1      <= 1'b0;
			fwd_s1    <= 1'b0;
			e_s2      <= 1'b0;
			e_s3      <= 1'b0;
			e_s4      <= 1'b0;
		end else begin
			hold_q   <= cfg_wr;
			total_q  <= ITEM_W'(area);
			thresh_q <= (ITEM_W'(w_eff) << 1) + ITEM_W'(2);

			if (cfg_wr && cfg_index == REG_IMAGE_WIDTH) begin
				width_q <= cfg_data;
			end
			if (cfg_wr && cfg_index == REG_IMAGE_HEIGHT) begin
				height_q <= cfg_data;
			end

			if (cfg_hit) begin
				items_q   <= '0;
				col_q     <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
			end else if (take) begin
				if (emit && last) begin
					items_q   <= '0;
					col_q     <= '0;
					out_row_q <= '0;
					out_col_q <= '0;
				end else begin
					items_q <= items_q + ITEM_W'(1);
					col_q   <= col_wrap ? '0 : col_q + COL_W'(1);
					if (emit) begin
						if (ocol_wrap) begin
							out_col_q <= '0;
							out_row_q <= out_row_q + ROW_W'(1);
						end else begin
							out_col_q <= out_col_q + COL_W'(1);
						end
					end
				end
			end

			case ({take && emit, pop})
				2'b10:   pend_q <= pend_q + PEND_W'(1);
				2'b01:   pend_q <= pend_q - PEND_W'(1);
				default: pend_q <= pend_q;
			endcase

			v_s1   <= take;
			e_s1   <= take && emit;
			fwd_s1 <= v_s1 && (col_s1 == col_q);
			e_s2   <= e_s1;
			e_s3   <= e_s2;
			e_s4   <= e_s3;
		end
	end

	// line buffers: one word per column, newest row in the low byte
	gb5_ram #(
		.WIDTH (LB_W),
		.DEPTH (MAX_WIDTH)
	) u_lbuf (
		.clk   (clk),
		.we    (v_s1),
		.waddr (col_s1),
		.wdata (lb_wdata),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	assign lb_rd    = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign lb_wdata = {lb_rd[3*PIX_W-1:0], val_s1};

	always_comb begin
		vec[0] = lb_rd[4*PIX_W-1:3*PIX_W];
		vec[1] = lb_rd[3*PIX_W-1:2*PIX_W];
		vec[2] = lb_rd[2*PIX_W-1:PIX_W];
		vec[3] = lb_rd[PIX_W-1:0];
		vec[4] = val_s1;
	end

	// window shifts left, new column enters on the right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 5; r++) begin
				for (int c = 0; c < 5; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (v_s1) begin
			for (int r = 0; r < 5; r++) begin
				for (int c = 0; c < 4; c++) begin
					win_q[r][c] <= win_q[r][c+1];
				end
				win_q[r][4] <= vec[r];
			end
		end
	end

	// masked row sums of the window
	always_comb begin
		for (int r = 0; r < 5; r++) begin
			rsum[r] = '0;
			for (int c = 0; c < 5; c++) begin
				if (cmask_s2[c]) begin
					rsum[r] = rsum[r] + RSUM_W'(win_q[r][c]) * RSUM_W'(KW[r][c]);
				end
			end
		end
	end

	assign prod = PROD_W'(sum_s4) * PROD_W'(DIV_RECIP);

	// payload pipeline
	always_ff @(posedge clk) begin
		val_s1      <= val;
		col_s1      <= col_q;
		rmask_s1    <= rmask;
		cmask_s1    <= cmask;
		last_s1     <= last;
		fwd_data_s1 <= lb_wdata;

		rmask_s2 <= rmask_s1;
		cmask_s2 <= cmask_s1;
		last_s2  <= last_s1;

		for (int r = 0; r < 5; r++) begin
			rsum_s3[r] <= rmask_s2[r] ? rsum[r] : '0;
		end
		last_s3 <= last_s2;

		sum_s4  <= SUM_W'(rsum_s3[0]) + SUM_W'(rsum_s3[1]) + SUM_W'(rsum_s3[2])
			+ SUM_W'(rsum_s3[3]) + SUM_W'(rsum_s3[4]);
		last_s4 <= last_s3;
	end

	assign push_data.pixel = prod[DIV_SHIFT +: PIX_W];
	assign push_data.last  = last_s4;

	gb5_outq #(
		.DEPTH (OUTQ_DEPTH)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (e_s4),
		.push_data (push_data),
		.valid     (out_valid),
		.ready     (out_ready),
		.data      (q_data)
	);

	assign pixel_out     = q_data.pixel;
	assign last_of_frame = q_data.last;

endmodule
